// ===== hdl/imf_pkg.sv =====
// Shared types and constants for the image mirror/flip unit.
package imf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FLIP_VERTICAL = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;

    // Register reset values
    localparam logic [6:0] FRAME_WIDTH_RST  = 7'd64;
    localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

    // Per-beat control from the address generator
    typedef struct packed {
        logic produce;    // previous frame held: this beat yields an output pixel
        logic frame_end;  // beat sits at the last raster position
    } t_step;

endpackage

// ===== hdl/image_mirror_flip_unit.sv =====
// Top level of the image mirror/flip unit: config, frame store and output stages.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_pixel_ch0..2
//  out     | source    | o_out_valid / i_out_ready | o_out_ch0..2, o_frame_end
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while the output does not stall: each beat does one
// frame store write and, once a previous frame is held, one mirrored read of the other
// bank in the same cycle (dual-port RAM); output passes RAM read reg, then output reg.
// Synchronous active-low reset clears counters, bank select and valid flags; the
// frame store is not cleared and no output appears during the first frame.
// A stalled output holds in the output register and the RAM read register.
module image_mirror_flip_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // pixel input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_pixel_ch0,
    input  logic [7:0] i_pixel_ch1,
    input  logic [7:0] i_pixel_ch2,
    // mirrored output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_ch0,
    output logic [7:0] o_out_ch1,
    output logic [7:0] o_out_ch2,
    output logic       o_frame_end,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    import imf_pkg::*;

    localparam int AW        = 1 + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int RAM_DEPTH = 1 << AW;

    logic          r_flip_vertical;
    logic [6:0]    r_frame_width;
    logic [6:0]    r_frame_height;

    logic          in_beat;
    logic          out_move;
    logic          s1_ready;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [23:0]   rd_data;
    t_step         step;

    logic          r_s1_valid;
    logic          r_s1_end;
    logic          r_out_valid;
    logic [23:0]   r_out_pix;
    logic          r_out_end;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_vertical <= 1'b0;
            r_frame_width   <= FRAME_WIDTH_RST;
            r_frame_height  <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FLIP_VERTICAL: r_flip_vertical <= i_cfg_data[0];
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Handshake and pipeline advance
    assign out_move   = r_s1_valid & (~r_out_valid | i_out_ready);
    assign s1_ready   = ~r_s1_valid | out_move;
    assign o_in_ready = s1_ready;
    assign in_beat    = i_in_valid & o_in_ready;
    assign rd_en      = in_beat & step.produce;

    imf_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (in_beat),
        .i_flip_vertical (r_flip_vertical),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .o_wr_addr       (wr_addr),
        .o_rd_addr       (rd_addr),
        .o_step          (step)
    );

    // Ping-pong frame store; write and read always hit different banks
    imf_ram #(
        .WIDTH (24),
        .DEPTH (RAM_DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (in_beat),
        .i_waddr (wr_addr),
        .i_wdata ({i_pixel_ch2, i_pixel_ch1, i_pixel_ch0}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Read stage flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_s1_valid <= step.produce;
            end else if (out_move) begin
                r_s1_valid <= 1'b0;
            end
            if (out_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_end <= step.frame_end;
        end
        if (out_move) begin
            r_out_pix <= rd_data;
            r_out_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ch0   = r_out_pix[7:0];
    assign o_out_ch1   = r_out_pix[15:8];
    assign o_out_ch2   = r_out_pix[23:16];
    assign o_frame_end = r_out_end;

`ifndef SYNTHESIS
    // A beat from the first frame never enters the read stage
    a_first_frame_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !step.produce) |=> !r_s1_valid)
        else $error("read stage filled by a beat without a previous frame");

    // A producing beat always lands in the read stage
    a_produce_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && step.produce) |=> r_s1_valid)
        else $error("producing beat lost before read stage");

    // A waiting read result is kept until the output register takes it
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_move) |=> (r_s1_valid && $stable(rd_data)))
        else $error("stalled read data dropped or changed");

    // Output register only loads from a valid read stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_s1_valid) |=> !r_out_valid)
        else $error("output valid without a read result");
`endif

endmodule

// ===== hdl/imf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/imf_addr_gen.sv =====
// Raster counters, bank toggle and write/mirror read address generation.
module imf_addr_gen #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_flip_vertical,
    input  logic [6:0]            i_frame_width,
    input  logic [6:0]            i_frame_height,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] o_wr_addr,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] o_rd_addr,
    output imf_pkg::t_step        o_step
);
    import imf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_bank, n_bank;
    logic          r_prev_ready, n_prev_ready;

    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [CW-1:0] col_c, rd_col;
    logic [RW-1:0] row_c, rd_row;
    logic          last_col, last_row, last;

    // Last column/row index in use, with out-of-range sizes clamped
    always_comb begin
        if (i_frame_width == 7'd0) begin
            w_last = '0;
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(i_frame_width - 7'd1);
        end
        if (i_frame_height == 7'd0) begin
            h_last = '0;
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(i_frame_height - 7'd1);
        end
    end

    // Position clipped to the frame in use
    assign last_col = (r_col >= w_last);
    assign last_row = (r_row >= h_last);
    assign last     = last_col & last_row;
    assign col_c    = last_col ? w_last : r_col;
    assign row_c    = last_row ? h_last : r_row;

    // Mirrored source position in the other bank
    assign rd_col = i_flip_vertical ? col_c : (w_last - col_c);
    assign rd_row = i_flip_vertical ? (h_last - row_c) : row_c;

    assign o_wr_addr = {r_bank, row_c, col_c};
    assign o_rd_addr = {~r_bank, rd_row, rd_col};

    assign o_step.produce   = r_prev_ready;
    assign o_step.frame_end = last;

    // Counter advance per accepted beat
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_bank       = r_bank;
        n_prev_ready = r_prev_ready;
        if (i_step) begin
            priority if (last) begin
                n_col        = '0;
                n_row        = '0;
                n_bank       = ~r_bank;
                n_prev_ready = 1'b1;
            end else if (last_col) begin
                n_col = '0;
                n_row = row_c + RW'(1);
            end else begin
                n_col = col_c + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_bank       <= 1'b0;
            r_prev_ready <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_bank       <= n_bank;
            r_prev_ready <= n_prev_ready;
        end
    end

endmodule
